/* rtl/core/eplru_pkg.sv */
`default_nettype none

package eplru_pkg;

	// Width of the entry number carried on both channels
	localparam int ENTRY_W = 9;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

endpackage

`default_nettype wire

/* rtl/core/eplru_if.sv */
`default_nettype none

interface eplru_req_if import eplru_pkg::*; ();
	logic               valid;
	logic               ready;
	op_t                op;
	logic [ENTRY_W-1:0] entry_index;

	modport source (output valid, output op, output entry_index, input ready);
	modport sink (input valid, input op, input entry_index, output ready);
endinterface

interface eplru_rsp_if import eplru_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ENTRY_W-1:0] granted_index;
	logic               evicted;
	logic               error;

	modport source (output valid, output granted_index, output evicted, output error,
		input ready);
	modport sink (input valid, input granted_index, input evicted, input error,
		output ready);
endinterface

`default_nettype wire

/* rtl/core/eplru_ram.sv */
`default_nettype none

module eplru_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/entry_pool_lru_evict_allocator.sv */
`default_nettype none

// channel | dir | payload                           | handshake
// req     | in  | op, entry_index                   | valid/ready
// rsp     | out | granted_index, evicted, error     | valid/ready
//
// Allocate pops the free head and links it in as newest; an allocate that reclaims
// the oldest entry first unlinks it. A free of an inactive or out-of-range entry gets
// an error. The steps run in turn since the single write port of the next-link memory
// is needed by an unlink, a push and a relink each.
// No clearing pass after reset: a fill counter marks entries never handed out,
// which read as free with their next link pointing one up.
// A new item is taken while a result waits in the output register.
module entry_pool_lru_evict_allocator import eplru_pkg::*; #(
	parameter int POOL_ENTRIES = 512
) (
	input logic          clk,
	input logic          arst_n,
	eplru_req_if.sink    req,
	eplru_rsp_if.source  rsp
);

	localparam int IW = $clog2(POOL_ENTRIES);
	localparam int CW = $clog2(POOL_ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_REL2,
		S_ALW,
		S_AL2,
		S_DONE
	} state_t;

	function automatic logic [IW-1:0] clamp_ix(input logic [IW-1:0] v);
		return (32'(v) < 32'(POOL_ENTRIES)) ? v : '0;
	endfunction

	state_t             state_q;
	op_t                op_q;
	logic [ENTRY_W-1:0] idx_q;
	logic [IW-1:0]      tgt_q;
	logic               evict_q;
	logic               err_q;
	logic [IW-1:0]      nxt_q;
	logic [IW-1:0]      free_head_q;
	logic [CW-1:0]      free_cnt_q;
	logic [IW-1:0]      newest_q;
	logic [IW-1:0]      oldest_q;
	logic [CW-1:0]      act_cnt_q;
	logic [CW-1:0]      fill_q;
	logic               fresh_s1;
	logic               out_valid_q;
	logic [ENTRY_W-1:0] out_granted_q;
	logic               out_evicted_q;
	logic               out_error_q;

	// next-link memory word: {in_use, next}
	logic           n_we;
	logic [IW-1:0]  n_waddr;
	logic [IW:0]    n_wdata;
	logic [IW:0]    n_rdata;
	logic           p_we;
	logic [IW-1:0]  p_waddr;
	logic [IW-1:0]  p_wdata;
	logic [IW-1:0]  p_rdata;
	logic [IW-1:0]  rd_addr;

	logic [31:0]    idx_ext;
	logic           idx_in_rng;
	logic           evict_need;
	logic [IW-1:0]  fresh_next;
	logic [IW-1:0]  nrd_next;
	logic           nrd_use;
	logic [IW-1:0]  p_ix;
	logic [IW-1:0]  n_ix;
	logic [IW-1:0]  alloc_nxt;
	logic           release_mode;
	logic           out_load;

	assign idx_ext      = 32'(req.entry_index);
	assign idx_in_rng   = idx_ext < 32'(POOL_ENTRIES);
	assign evict_need   = (free_cnt_q == '0) && (act_cnt_q != '0);
	assign release_mode = (op_q == OP_FREE) || evict_q;
	assign out_load     = !out_valid_q || rsp.ready;

	// Entries at or above the fill mark are read as free, their next link one up
	assign fresh_next = clamp_ix(IW'(32'(tgt_q) + 32'd1));
	assign nrd_next   = fresh_s1 ? fresh_next : n_rdata[IW-1:0];
	assign nrd_use    = fresh_s1 ? 1'b0 : n_rdata[IW];
	assign p_ix       = clamp_ix(p_rdata);
	assign n_ix       = clamp_ix(nrd_next);
	// after an eviction the popped entry links to the old free head
	assign alloc_nxt  = (state_q == S_ALW) ? nxt_q : nrd_next;

	always_comb begin
		if (req.op == OP_FREE) begin
			rd_addr = idx_ext[IW-1:0];
		end else if (evict_need) begin
			rd_addr = oldest_q;
		end else begin
			rd_addr = free_head_q;
		end
	end

	always_comb begin
		n_we    = 1'b0;
		n_waddr = tgt_q;
		n_wdata = '0;
		p_we    = 1'b0;
		p_waddr = tgt_q;
		p_wdata = tgt_q;
		case (state_q)
			S_EXEC, S_ALW: begin
				if (state_q == S_EXEC && release_mode) begin
					if (op_q != OP_FREE || nrd_use) begin
						if (tgt_q != newest_q) begin
							n_we    = 1'b1;
							n_waddr = p_ix;
							n_wdata = {1'b1, n_ix};
						end
						if (tgt_q != oldest_q) begin
							p_we    = 1'b1;
							p_waddr = n_ix;
							p_wdata = p_ix;
						end
					end
				end else begin
					n_we    = 1'b1;
					n_waddr = tgt_q;
					n_wdata = {1'b1, (act_cnt_q != '0) ? newest_q : alloc_nxt};
					p_we    = 1'b1;
					p_waddr = tgt_q;
					p_wdata = tgt_q;
				end
			end
			S_REL2: begin
				n_we    = 1'b1;
				n_waddr = tgt_q;
				n_wdata = {1'b0, free_head_q};
			end
			S_AL2: begin
				if (act_cnt_q != '0) begin
					p_we    = 1'b1;
					p_waddr = newest_q;
					p_wdata = tgt_q;
				end
			end
			default: begin
			end
		endcase
	end

	eplru_ram #(.WIDTH(IW + 1), .DEPTH(POOL_ENTRIES)) u_next_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.raddr (rd_addr),
		.rdata (n_rdata)
	);

	eplru_ram #(.WIDTH(IW), .DEPTH(POOL_ENTRIES)) u_prev_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (rd_addr),
		.rdata (p_rdata)
	);

	always_ff @(posedge clk) begin
		fresh_s1 <= 32'(rd_addr) >= 32'(fill_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_head_q <= '0;
			free_cnt_q  <= CW'(POOL_ENTRIES);
			newest_q    <= '0;
			oldest_q    <= '0;
			act_cnt_q   <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.op;
						idx_q   <= req.entry_index;
						tgt_q   <= rd_addr;
						evict_q <= (req.op == OP_ALLOC) && evict_need;
						err_q   <= (req.op == OP_FREE) && !idx_in_rng;
						state_q <= ((req.op == OP_FREE) && !idx_in_rng) ? S_DONE : S_EXEC;
					end
				end
				S_EXEC, S_ALW: begin
					if (state_q == S_EXEC && release_mode) begin
						if (op_q == OP_FREE && !nrd_use) begin
							err_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							if (tgt_q == newest_q) begin
								newest_q <= n_ix;
							end
							if (tgt_q == oldest_q) begin
								oldest_q <= p_ix;
							end
							if (act_cnt_q != '0) begin
								act_cnt_q <= act_cnt_q - 1'b1;
							end
							state_q <= S_REL2;
						end
					end else begin
						free_head_q <= clamp_ix(alloc_nxt);
						if (free_cnt_q != '0) begin
							free_cnt_q <= free_cnt_q - 1'b1;
						end
						if (act_cnt_q == '0) begin
							oldest_q <= tgt_q;
						end
						if (state_q == S_EXEC && fresh_s1) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= S_AL2;
					end
				end
				S_REL2: begin
					free_head_q <= tgt_q;
					free_cnt_q  <= free_cnt_q + 1'b1;
					if (evict_q) begin
						nxt_q   <= free_head_q;
						state_q <= S_ALW;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_AL2: begin
					newest_q  <= tgt_q;
					act_cnt_q <= act_cnt_q + 1'b1;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_granted_q <= (op_q == OP_FREE) ? idx_q : ENTRY_W'(32'(tgt_q));
						out_evicted_q <= evict_q;
						out_error_q   <= err_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.granted_index = out_granted_q;
	assign rsp.evicted       = out_evicted_q;
	assign rsp.error         = out_error_q;

	// between items the free and active counts add up to the pool size
	a_pool_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
		(32'(free_cnt_q) + 32'(act_cnt_q) == 32'(POOL_ENTRIES)))
		else $error("free and active counts do not cover the pool");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != S_IDLE))
		else $error("item accepted but sequencer stayed idle");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_load) |=> (rsp.valid && state_q == S_IDLE))
		else $error("finished item did not reach the output register");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(fill_q) <= 32'(POOL_ENTRIES)) && (32'(free_cnt_q) <= 32'(POOL_ENTRIES)))
		else $error("fill mark or free count beyond pool size");

endmodule

`default_nettype wire

/* tb/tb_entry_pool_lru_evict_allocator.sv */
`default_nettype none

module tb_entry_pool_lru_evict_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import eplru_pkg::*;

	localparam int POOL = 512;

	typedef struct {
		logic [ENTRY_W-1:0] granted;
		logic               evicted;
		logic               error;
	} pool_rsp_t;

	typedef struct {
		op_t                op;
		logic [ENTRY_W-1:0] idx;
		bit                 typed;
		logic [ENTRY_W-1:0] granted;
		logic               evicted;
		logic               error;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	eplru_req_if req_ch ();
	eplru_rsp_if rsp_ch ();

	entry_pool_lru_evict_allocator #(.POOL_ENTRIES(POOL)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the pool
	int unsigned nxt [POOL];
	int unsigned prv [POOL];
	bit          busy [POOL];
	int unsigned fhead, fcnt, newest, oldest, acnt;

	pool_rsp_t rsp_expected [$];
	int mismatches = 0;
	int n_alloc = 0, n_evict = 0, n_free = 0, n_reject = 0;
	int recv_stall = 0;

	function automatic int unsigned clip(int unsigned v);
		return v < POOL ? v : 0;
	endfunction

	function automatic void pool_clear();
		for (int i = 0; i < POOL; i++) begin
			nxt[i] = i + 1;
			prv[i] = '0;
			busy[i] = 1'b0;
		end
		fhead = 0;
		fcnt = POOL;
		newest = 0;
		oldest = 0;
		acnt = 0;
	endfunction

	// take an active entry out of the active list, push it on the free list
	function automatic void pool_unlink(int unsigned e);
		int unsigned p, n;
		p = clip(prv[e]);
		n = clip(nxt[e]);
		if (e == newest)
			newest = n;
		else
			nxt[p] = n;
		if (e == oldest)
			oldest = p;
		else
			prv[n] = p;
		if (acnt > 0)
			acnt--;
		busy[e] = 1'b0;
		nxt[e] = fhead;
		fhead = e;
		fcnt++;
	endfunction

	function automatic pool_rsp_t pool_step(op_t op, logic [ENTRY_W-1:0] idx);
		pool_rsp_t r;
		int unsigned e;
		r.granted = idx;
		r.evicted = 1'b0;
		r.error = 1'b0;
		if (op == OP_ALLOC) begin
			if (fcnt == 0 && acnt != 0) begin
				pool_unlink(clip(oldest));
				r.evicted = 1'b1;
				n_evict++;
			end
			e = clip(fhead);
			fhead = clip(nxt[e]);
			if (fcnt > 0)
				fcnt--;
			busy[e] = 1'b1;
			prv[e] = e;
			if (acnt == 0) begin
				oldest = e;
			end else begin
				nxt[e] = newest;
				prv[clip(newest)] = e;
			end
			newest = e;
			acnt++;
			r.granted = e[ENTRY_W-1:0];
			n_alloc++;
		end else begin
			n_free++;
			if (idx < POOL && busy[idx]) begin
				pool_unlink(idx);
			end else begin
				r.error = 1'b1;
				n_reject++;
			end
		end
		return r;
	endfunction

	function automatic logic [ENTRY_W-1:0] pick_active();
		int unsigned start, j;
		start = $urandom_range(POOL - 1);
		for (int k = 0; k < POOL; k++) begin
			j = (start + k) % POOL;
			if (busy[j])
				return j[ENTRY_W-1:0];
		end
		return start[ENTRY_W-1:0];
	endfunction

	task automatic note_mismatch(string what, int got, int want);
		$display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// present one item and wait for the handshake; valid is left high
	task automatic issue(input op_t op, input logic [ENTRY_W-1:0] idx, input bit typed,
		input pool_rsp_t typed_rsp);
		pool_rsp_t want;
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.entry_index <= idx;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		want = pool_step(op, idx);
		if (typed)
			want = typed_rsp;
		rsp_expected.push_back(want);
	endtask

	always @(posedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin
		pool_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (rsp_expected.size() == 0) begin
				$display("[%0t] result item with nothing expected: granted %0d", $realtime,
					rsp_ch.granted_index);
				mismatches++;
			end else begin
				want = rsp_expected.pop_front();
				if (rsp_ch.granted_index !== want.granted)
					note_mismatch("granted_index", rsp_ch.granted_index, want.granted);
				if (rsp_ch.evicted !== want.evicted)
					note_mismatch("evicted", rsp_ch.evicted, want.evicted);
				if (rsp_ch.error !== want.error)
					note_mismatch("error", rsp_ch.error, want.error);
			end
		end
	end

	dir_row_t directed [23] = '{
		'{OP_ALLOC, 9'd0,   1'b1, 9'd0,   1'b0, 1'b0},
		'{OP_ALLOC, 9'd0,   1'b1, 9'd1,   1'b0, 1'b0},
		'{OP_ALLOC, 9'd511, 1'b1, 9'd2,   1'b0, 1'b0},
		'{OP_FREE,  9'd1,   1'b1, 9'd1,   1'b0, 1'b0},
		'{OP_FREE,  9'd1,   1'b1, 9'd1,   1'b0, 1'b1},  // double free
		'{OP_FREE,  9'd511, 1'b1, 9'd511, 1'b0, 1'b1},  // never handed out
		'{OP_FREE,  9'd0,   1'b1, 9'd0,   1'b0, 1'b0},  // oldest
		'{OP_FREE,  9'd2,   1'b1, 9'd2,   1'b0, 1'b0},  // sole active entry
		'{OP_FREE,  9'd2,   1'b1, 9'd2,   1'b0, 1'b1},
		'{OP_ALLOC, 9'd0,   1'b1, 9'd2,   1'b0, 1'b0},  // LIFO reuse of freed entries
		'{OP_ALLOC, 9'd0,   1'b1, 9'd0,   1'b0, 1'b0},
		'{OP_ALLOC, 9'd0,   1'b1, 9'd1,   1'b0, 1'b0},
		'{OP_ALLOC, 9'd0,   1'b1, 9'd3,   1'b0, 1'b0},
		'{OP_FREE,  9'd0,   1'b1, 9'd0,   1'b0, 1'b0},  // middle of the list
		'{OP_ALLOC, 9'd0,   1'b1, 9'd0,   1'b0, 1'b0},
		'{OP_FREE,  9'd3,   1'b1, 9'd3,   1'b0, 1'b0},
		'{OP_FREE,  9'd0,   1'b1, 9'd0,   1'b0, 1'b0},  // newest
		'{OP_FREE,  9'd2,   1'b1, 9'd2,   1'b0, 1'b0},
		'{OP_FREE,  9'd1,   1'b1, 9'd1,   1'b0, 1'b0},
		'{OP_ALLOC, 9'd170, 1'b0, 9'd0,   1'b0, 1'b0},
		'{OP_ALLOC, 9'd341, 1'b0, 9'd0,   1'b0, 1'b0},
		'{OP_FREE,  9'd256, 1'b1, 9'd256, 1'b0, 1'b1},
		'{OP_FREE,  9'd510, 1'b1, 9'd510, 1'b0, 1'b1}
	};

	// per phase: item count, alloc share, sender idle, receiver stall
	int phase_items [4] = '{300, 300, 250, 250};
	int phase_alloc [4] = '{92, 92, 60, 20};
	int phase_idle  [4] = '{0, 70, 0, 22};
	int phase_stall [4] = '{0, 0, 70, 22};

	initial begin
		pool_rsp_t typed_rsp;
		op_t op;
		logic [ENTRY_W-1:0] idx;
		logic [ENTRY_W-1:0] last_freed;
		int roll, gap, drain;

		req_ch.valid = 1'b0;
		req_ch.op = OP_ALLOC;
		req_ch.entry_index = '0;
		last_freed = '0;
		pool_clear();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			typed_rsp.granted = directed[i].granted;
			typed_rsp.evicted = directed[i].evicted;
			typed_rsp.error = directed[i].error;
			issue(directed[i].op, directed[i].idx, directed[i].typed, typed_rsp);
		end

		for (int ph = 0; ph < 4; ph++) begin
			recv_stall = phase_stall[ph];
			for (int n = 0; n < phase_items[ph]; n++) begin
				roll = $urandom_range(99);
				if (roll < phase_alloc[ph]) begin
					op = OP_ALLOC;
					idx = ENTRY_W'($urandom);
				end else if (roll < 96) begin
					op = OP_FREE;
					idx = (acnt != 0) ? pick_active() : ENTRY_W'($urandom);
				end else begin
					// noise: stray index or a repeat of the last free
					op = OP_FREE;
					idx = $urandom_range(1) ? ENTRY_W'($urandom) : last_freed;
				end
				if (op == OP_FREE)
					last_freed = idx;
				gap = 0;
				while (gap < 20 && $urandom_range(99) < phase_idle[ph])
					gap++;
				if (gap > 0) begin
					req_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				issue(op, idx, 1'b0, typed_rsp);
			end
		end
		req_ch.valid <= 1'b0;

		while (rsp_expected.size() != 0)
			@(posedge clk);
		recv_stall = 0;
		drain = 20;
		repeat (drain) @(posedge clk);

		$display("%0d allocates (%0d reclaimed the oldest entry), %0d frees (%0d rejected)",
			n_alloc, n_evict, n_free, n_reject);
		$display("phases: steady flow, sender gaps, receiver stalls, both; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("tb_entry_pool_lru_evict_allocator: done, clean");
		else
			$display("tb_entry_pool_lru_evict_allocator: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d result items outstanding", rsp_expected.size());
		$display("tb_entry_pool_lru_evict_allocator: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
